// ----- rtl/mlh_pkg.sv -----
// shared types and codes for the monotone max line hull unit
// no dependencies; used by the top level, the checker and the testbench
package mlh_pkg;

    localparam int FIELD_W = 32;
    localparam int VALUE_W = 64;

    localparam logic MODE_ADD     = 1'b0;
    localparam logic MODE_QUERY   = 1'b1;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef struct packed {
        logic                       mode;
        logic signed [FIELD_W-1:0]  slope;
        logic signed [FIELD_W-1:0]  intercept;
        logic signed [FIELD_W-1:0]  query_x;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  max_value;
        logic                       status;
        logic                       overflowed;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_MUL1,
        ST_ADD_MUL2,
        ST_ADD_CMP,
        ST_ADD_PUSH,
        ST_Q_RD0,
        ST_Q_MUL0,
        ST_Q_ADD0,
        ST_Q_CHK,
        ST_Q_MUL1,
        ST_Q_ADD1,
        ST_Q_CMP,
        ST_Q_OUT
    } t_state;

endpackage

// ----- rtl/mlh_line_ram.sv -----
// line stack storage: slope and intercept per entry, one write and one read port
// registered read data; no dependencies
module mlh_line_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 32
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic signed [DW-1:0] i_wslope,
    input  logic signed [DW-1:0] i_wicpt,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr,
    output logic signed [DW-1:0] o_rslope,
    output logic signed [DW-1:0] o_ricpt
);

    logic [2*DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wslope, i_wicpt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            {o_rslope, o_ricpt} <= r_mem[i_raddr];
        end
    end

endmodule

// ----- rtl/mlh_mul.sv -----
// shared signed multiplier with registered product
// used for both cross products and line values; no dependencies
module mlh_mul #(
    parameter int MW = 33
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [MW-1:0]   i_op_a,
    input  logic signed [MW-1:0]   i_op_b,
    output logic signed [2*MW-1:0] o_prod
);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_prod <= (2*MW)'(i_op_a) * (2*MW)'(i_op_b);
        end
    end

endmodule

// ----- rtl/monotone_max_line_hull_unit.sv -----
// top level of the monotone max line hull: sequencer, stack pointers and datapath
// uses mlh_pkg, mlh_line_ram and mlh_mul

// Keeps the upper envelope of lines y = a*x + b on a stack and answers maximum
// queries at nondecreasing x; adds must come with nondecreasing slopes. Each beat
// is handled alone while o_in_ready is low. All work goes through one multiplier
// and one memory read port. An add onto a stack of two or more lines tests the
// top line: each test is a read, two cross products and a compare, and there is
// one test more than pops unless the pops leave a single line. A shorter add only
// pushes, and an add onto a full stack is dropped. A query reads and values the
// line at the pointer, then reads, values and compares the next line and moves on
// while it is higher; an empty hull skips to the output step, which can stall.
// The result register lets an add be accepted while a query result is not yet
// taken. Only the low COEF_WIDTH bits of slope, intercept and query_x are used,
// sign-extended. No clearing pass is needed after reset.
module monotone_max_line_hull_unit #(
    parameter int MAX_LINES  = 1024,
    parameter int COEF_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mlh_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mlh_pkg::t_out_item o_out_data
);

    localparam int AW   = $clog2(MAX_LINES);
    localparam int CNTW = $clog2(MAX_LINES + 1);
    localparam int CW   = COEF_WIDTH;
    localparam int MW   = CW + 1;
    localparam int PW   = 2 * MW;
    localparam logic [CNTW-1:0] FULL = CNTW'(MAX_LINES);

    mlh_pkg::t_state r_state, n_state;

    logic [CNTW-1:0]        r_count;
    logic [AW-1:0]          r_ptr;
    logic                   r_ovf;
    logic                   r_empty;
    logic signed [CW-1:0]   r_new_a, r_new_b, r_x;
    logic signed [CW-1:0]   r_top_a, r_top_b;
    logic signed [PW-1:0]   r_hold, r_cur, r_nxt;
    logic                   r_out_valid;
    mlh_pkg::t_out_item     r_out;

    logic                   w_re, w_we, w_mul_en;
    logic [AW-1:0]          w_raddr;
    logic signed [MW-1:0]   w_op_a, w_op_b;
    logic signed [CW-1:0]   w_rd_a, w_rd_b;
    logic signed [PW-1:0]   w_prod;
    logic                   w_ge, w_lt, w_more, w_accept, w_out_free;

    mlh_line_ram #(.DEPTH(MAX_LINES), .AW(AW), .DW(CW)) u_ram (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (AW'(r_count)),
        .i_wslope (r_new_a),
        .i_wicpt  (r_new_b),
        .i_re     (w_re),
        .i_raddr  (w_raddr),
        .o_rslope (w_rd_a),
        .o_ricpt  (w_rd_b)
    );

    mlh_mul #(.MW(MW)) u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_op_a (w_op_a),
        .i_op_b (w_op_b),
        .o_prod (w_prod)
    );

    assign w_accept   = i_in_valid && (r_state == mlh_pkg::ST_IDLE);
    assign w_ge       = r_hold >= w_prod;
    assign w_lt       = r_cur < r_nxt;
    assign w_more     = (CNTW'(r_ptr) + CNTW'(1)) < r_count;
    assign w_out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mlh_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.mode == mlh_pkg::MODE_QUERY) begin
                        n_state = (r_count == '0) ? mlh_pkg::ST_Q_OUT : mlh_pkg::ST_Q_RD0;
                    end else if (r_count == FULL) begin
                        n_state = mlh_pkg::ST_IDLE;
                    end else if (r_count < CNTW'(2)) begin
                        n_state = mlh_pkg::ST_ADD_PUSH;
                    end else begin
                        n_state = mlh_pkg::ST_ADD_RD;
                    end
                end
            end
            mlh_pkg::ST_ADD_RD:   n_state = mlh_pkg::ST_ADD_MUL1;
            mlh_pkg::ST_ADD_MUL1: n_state = mlh_pkg::ST_ADD_MUL2;
            mlh_pkg::ST_ADD_MUL2: n_state = mlh_pkg::ST_ADD_CMP;
            mlh_pkg::ST_ADD_CMP: begin
                if (w_ge && (r_count > CNTW'(2))) begin
                    n_state = mlh_pkg::ST_ADD_RD;
                end else begin
                    n_state = mlh_pkg::ST_ADD_PUSH;
                end
            end
            mlh_pkg::ST_ADD_PUSH: n_state = mlh_pkg::ST_IDLE;
            mlh_pkg::ST_Q_RD0:    n_state = mlh_pkg::ST_Q_MUL0;
            mlh_pkg::ST_Q_MUL0:   n_state = mlh_pkg::ST_Q_ADD0;
            mlh_pkg::ST_Q_ADD0:   n_state = mlh_pkg::ST_Q_CHK;
            mlh_pkg::ST_Q_CHK:    n_state = w_more ? mlh_pkg::ST_Q_MUL1 : mlh_pkg::ST_Q_OUT;
            mlh_pkg::ST_Q_MUL1:   n_state = mlh_pkg::ST_Q_ADD1;
            mlh_pkg::ST_Q_ADD1:   n_state = mlh_pkg::ST_Q_CMP;
            mlh_pkg::ST_Q_CMP:    n_state = w_lt ? mlh_pkg::ST_Q_CHK : mlh_pkg::ST_Q_OUT;
            mlh_pkg::ST_Q_OUT:    n_state = w_out_free ? mlh_pkg::ST_IDLE : mlh_pkg::ST_Q_OUT;
            default:              n_state = mlh_pkg::ST_IDLE;
        endcase
    end

    // memory and multiplier control
    always_comb begin
        w_re     = 1'b0;
        w_we     = 1'b0;
        w_raddr  = r_ptr;
        w_mul_en = 1'b0;
        w_op_a   = MW'(w_rd_a);
        w_op_b   = MW'(r_x);
        case (r_state)
            mlh_pkg::ST_ADD_RD: begin
                w_re    = 1'b1;
                w_raddr = AW'(r_count - CNTW'(2));
            end
            mlh_pkg::ST_ADD_MUL1: begin
                // (b2 - b1) * (a1 - a0)
                w_mul_en = 1'b1;
                w_op_a   = MW'(r_new_b) - MW'(r_top_b);
                w_op_b   = MW'(r_top_a) - MW'(w_rd_a);
            end
            mlh_pkg::ST_ADD_MUL2: begin
                // (b1 - b0) * (a2 - a1)
                w_mul_en = 1'b1;
                w_op_a   = MW'(r_top_b) - MW'(w_rd_b);
                w_op_b   = MW'(r_new_a) - MW'(r_top_a);
            end
            mlh_pkg::ST_ADD_PUSH: w_we = 1'b1;
            mlh_pkg::ST_Q_RD0:    w_re = 1'b1;
            mlh_pkg::ST_Q_CHK: begin
                w_re    = w_more;
                w_raddr = r_ptr + AW'(1);
            end
            mlh_pkg::ST_Q_MUL0,
            mlh_pkg::ST_Q_MUL1:   w_mul_en = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mlh_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // stack control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ptr       <= '0;
            r_ovf       <= 1'b0;
        end else begin
            case (r_state)
                mlh_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        if (i_in_data.mode == mlh_pkg::MODE_QUERY) begin
                            if (r_count != '0 && CNTW'(r_ptr) >= r_count) begin
                                r_ptr <= AW'(r_count - CNTW'(1));
                            end
                        end else if (r_count == FULL) begin
                            r_ovf <= 1'b1;
                        end
                    end
                end
                mlh_pkg::ST_ADD_CMP: begin
                    if (w_ge) begin
                        r_count <= r_count - CNTW'(1);
                        if (CNTW'(r_ptr) > r_count - CNTW'(1)) begin
                            r_ptr <= AW'(r_count - CNTW'(1));
                        end
                    end
                end
                mlh_pkg::ST_ADD_PUSH: r_count <= r_count + CNTW'(1);
                mlh_pkg::ST_Q_CMP: begin
                    if (w_lt) begin
                        r_ptr <= r_ptr + AW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result register: loaded as a query finishes, cleared when its beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == mlh_pkg::ST_Q_OUT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            mlh_pkg::ST_IDLE: begin
                if (w_accept) begin
                    r_new_a <= i_in_data.slope[CW-1:0];
                    r_new_b <= i_in_data.intercept[CW-1:0];
                    r_x     <= i_in_data.query_x[CW-1:0];
                    r_empty <= (r_count == '0);
                    r_cur   <= '0;
                end
            end
            mlh_pkg::ST_ADD_MUL2: r_hold <= w_prod;
            mlh_pkg::ST_ADD_CMP: begin
                // popped: the second line becomes the cached top
                if (w_ge) begin
                    r_top_a <= w_rd_a;
                    r_top_b <= w_rd_b;
                end
            end
            mlh_pkg::ST_ADD_PUSH: begin
                r_top_a <= r_new_a;
                r_top_b <= r_new_b;
            end
            mlh_pkg::ST_Q_ADD0: r_cur <= w_prod + PW'(w_rd_b);
            mlh_pkg::ST_Q_ADD1: r_nxt <= w_prod + PW'(w_rd_b);
            mlh_pkg::ST_Q_CMP: begin
                if (w_lt) begin
                    r_cur <= r_nxt;
                end
            end
            mlh_pkg::ST_Q_OUT: begin
                if (w_out_free) begin
                    r_out.max_value  <= mlh_pkg::VALUE_W'(r_cur);
                    r_out.status     <= r_empty ? mlh_pkg::STATUS_EMPTY : mlh_pkg::STATUS_OK;
                    r_out.overflowed <= r_ovf;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready  = (r_state == mlh_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/mlh_checker.sv -----
// port-level checks for the monotone max line hull unit, bound to the top level
// uses mlh_pkg
module mlh_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               o_in_ready,
    input  mlh_pkg::t_in_item  i_in_data,
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  mlh_pkg::t_out_item o_out_data
);

    logic r_seen_ovf;

    // remembers an overflow already reported on some result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_ovf <= 1'b0;
        end else if (o_out_valid && i_out_ready && o_out_data.overflowed) begin
            r_seen_ovf <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("stalled result payload changed");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == mlh_pkg::STATUS_EMPTY)
            |-> (o_out_data.max_value == '0))
        else $error("empty hull result carries a nonzero value");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_seen_ovf |-> o_out_data.overflowed)
        else $error("overflow flag cleared after being reported");

    // a query beat always leaves the input not ready in the cycle after it is taken
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.mode == mlh_pkg::MODE_QUERY)
            |=> !o_in_ready)
        else $error("input still ready right after a query beat");

endmodule

bind monotone_max_line_hull_unit mlh_checker u_mlh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ----- tb/tb.sv -----
// self-checking testbench for monotone_max_line_hull_unit: directed table, random line/query
// streams with idling and back pressure, then a fill to a full stack; uses mlh_pkg
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mlh_pkg::*;

    localparam int HULL_DEPTH = 1024;
    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
    localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
    // value of the steepest line at the far end, either sign
    localparam logic signed [63:0] CORNER_VALUE = 64'sh3FFF_FFFF_8000_0000;
    localparam logic signed [63:0] NEG_2_31 = 64'shFFFF_FFFF_8000_0000;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] slope;
        logic signed [31:0] intercept;
        logic signed [31:0] query_x;
        logic               typed;
        logic signed [63:0] want_value;
        logic               want_status;
    } t_script_row;

    localparam int SCRIPT_LEN = 21;
    localparam t_script_row SCRIPT [SCRIPT_LEN] = '{
        // empty hull right after reset
        '{MODE_QUERY, 32'sd0, 32'sd0, 32'sd0, 1'b1, 64'sd0, STATUS_EMPTY},
        '{MODE_QUERY, MAX32, MAX32, MIN32, 1'b1, 64'sd0, STATUS_EMPTY},
        // most negative line, read at the low end and at zero
        '{MODE_ADD, MIN32, MIN32, MAX32, 1'b0, 64'sd0, STATUS_OK},
        '{MODE_QUERY, 32'sd0, 32'sd0, MIN32, 1'b1, CORNER_VALUE, STATUS_OK},
        '{MODE_QUERY, 32'sd0, 32'sd0, 32'sd0, 1'b1, NEG_2_31, STATUS_OK},
        // same slope, higher intercept
        '{MODE_ADD, MIN32, MAX32, 32'sd0, 1'b0, 64'sd0, STATUS_OK},
        '{MODE_QUERY, 32'sd0, 32'sd0, 32'sd0, 1'b0, 64'sd0, STATUS_OK},
        '{MODE_ADD, 32'sd0, 32'sd0, 32'sd0, 1'b0, 64'sd0, STATUS_OK},
        '{MODE_ADD, MAX32, MAX32, 32'sd0, 1'b0, 64'sd0, STATUS_OK},
        '{MODE_QUERY, 32'sd0, 32'sd0, MAX32, 1'b1, CORNER_VALUE, STATUS_OK},
        '{MODE_QUERY, 32'sd0, 32'sd0, MAX32, 1'b0, 64'sd0, STATUS_OK},
        // equal slopes, lower then higher intercept
        '{MODE_ADD, MAX32, -32'sd5, 32'sd0, 1'b0, 64'sd0, STATUS_OK},
        '{MODE_ADD, MAX32, MAX32, 32'sd0, 1'b0, 64'sd0, STATUS_OK},
        // x and slope out of order
        '{MODE_QUERY, 32'sd0, 32'sd0, -32'sd7, 1'b0, 64'sd0, STATUS_OK},
        '{MODE_ADD, -32'sd3, 32'sd1000, 32'sd0, 1'b0, 64'sd0, STATUS_OK},
        '{MODE_QUERY, 32'sd0, 32'sd0, 32'sd5, 1'b0, 64'sd0, STATUS_OK},
        '{MODE_ADD, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 1'b0, 64'sd0, STATUS_OK},
        '{MODE_QUERY, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, 64'sd0, STATUS_OK},
        '{MODE_ADD, 32'sh7FFF_0000, 32'sd1, MIN32, 1'b0, 64'sd0, STATUS_OK},
        '{MODE_QUERY, 32'sd0, 32'sd0, MAX32, 1'b0, 64'sd0, STATUS_OK},
        '{MODE_QUERY, 32'sd0, 32'sd0, MIN32, 1'b0, 64'sd0, STATUS_OK}
    };

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    monotone_max_line_hull_unit #(
        .MAX_LINES (HULL_DEPTH),
        .COEF_WIDTH(32)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // envelope kept alongside the block
    logic signed [31:0] hull_slope [HULL_DEPTH];
    logic signed [31:0] hull_icpt  [HULL_DEPTH];
    int unsigned        hull_count = 0;
    int unsigned        hull_ptr = 0;
    bit                 hull_ovf = 1'b0;

    t_out_item   max_answers_q [$];
    int unsigned fail_count = 0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          pressure_req = 1'b0;
    bit          pressure_seen = 1'b0;
    int unsigned stall_left = 0;

    // running coefficients of the current sorted stream
    longint      seg_slope = -1000;
    longint      seg_x = -1000;
    int unsigned seg_left = 0;
    int unsigned seg_mag = 1000;

    // top line is dropped when the new line covers it together with the one below
    function automatic bit top_line_dominated(input logic signed [31:0] a_new,
                                              input logic signed [31:0] b_new);
        logic signed [66:0] a0, a1, a2, b0, b1, b2;
        a2 = a_new;
        b2 = b_new;
        a1 = hull_slope[hull_count - 1];
        b1 = hull_icpt[hull_count - 1];
        a0 = hull_slope[hull_count - 2];
        b0 = hull_icpt[hull_count - 2];
        return (b2 - b1) * (a1 - a0) >= (b1 - b0) * (a2 - a1);
    endfunction

    function automatic longint line_at(input int unsigned idx, input longint x);
        return longint'(hull_slope[idx]) * x + longint'(hull_icpt[idx]);
    endfunction

    function automatic bit hull_apply(input t_in_item beat, output t_out_item res);
        longint x;
        res = '0;
        if (beat.mode == MODE_ADD) begin
            if (hull_count >= HULL_DEPTH) begin
                hull_ovf = 1'b1;
                return 1'b0;
            end
            while (hull_count >= 2 && top_line_dominated(beat.slope, beat.intercept)) begin
                hull_count--;
                if (hull_ptr > hull_count) hull_ptr = hull_count;
            end
            hull_slope[hull_count] = beat.slope;
            hull_icpt[hull_count]  = beat.intercept;
            hull_count++;
            return 1'b0;
        end
        x = beat.query_x;
        if (hull_count == 0) begin
            res.max_value = '0;
            res.status    = STATUS_EMPTY;
        end else begin
            if (hull_ptr >= hull_count) hull_ptr = hull_count - 1;
            while (hull_ptr + 1 < hull_count && line_at(hull_ptr, x) < line_at(hull_ptr + 1, x))
                hull_ptr++;
            res.max_value = line_at(hull_ptr, x);
            res.status    = STATUS_OK;
        end
        res.overflowed = hull_ovf;
        return 1'b1;
    endfunction

    // offer one beat, hold it until taken, then record what it should produce
    task automatic offer(input t_in_item beat, input bit typed, input t_out_item want);
        t_out_item predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (!in_ready);
        if (hull_apply(beat, predicted))
            max_answers_q.insert(max_answers_q.size(), typed ? want : predicted);
    endtask

    function automatic longint bump(input longint v, input longint step);
        return (v + step > 64'sd2147483647) ? 64'sd2147483647 : v + step;
    endfunction

    // mostly sorted streams with random content; restarts and noise break the order
    function automatic t_in_item next_random_beat();
        t_in_item beat;
        longint   span;
        longint   step;
        beat.mode      = 1'($urandom_range(0, 1));
        beat.slope     = $urandom;
        beat.intercept = $urandom;
        beat.query_x   = $urandom;
        if (seg_left == 0) begin
            seg_left = $urandom_range(40, 160);
            case ($urandom_range(0, 2))
                0: seg_mag = 1000;
                1: seg_mag = 1 << 20;
                default: seg_mag = 0;
            endcase
            if ($urandom_range(0, 99) < 30) begin
                span      = (seg_mag == 0) ? 64'sd2147483648 : longint'(seg_mag);
                seg_slope = -span;
                seg_x     = -span;
            end
        end
        seg_left--;
        if ($urandom_range(0, 99) < 8) return beat;
        if (seg_mag == 0) step = longint'($urandom_range(0, 1 << 26));
        else step = longint'($urandom_range(0, seg_mag / 16));
        if ($urandom_range(0, 9) == 0) step = 0;
        if ($urandom_range(0, 99) < 55) begin
            beat.mode = MODE_ADD;
            seg_slope = bump(seg_slope, step);
            beat.slope = 32'(seg_slope);
            if (seg_mag != 0)
                beat.intercept = 32'(longint'($urandom_range(0, 2 * seg_mag))
                                     - longint'(seg_mag));
        end else begin
            beat.mode    = MODE_QUERY;
            seg_x        = bump(seg_x, step);
            beat.query_x = 32'(seg_x);
        end
        return beat;
    endfunction

    task automatic run_random(input int unsigned n);
        repeat (n) offer(next_random_beat(), 1'b0, '0);
    endtask

    // tangent lines of a parabola never cover each other, so the stack grows to full
    task automatic fill_to_overflow();
        t_in_item    beat;
        int          j;
        int unsigned guard;
        j = -600;
        guard = 0;
        while (hull_count < HULL_DEPTH && guard < 3000) begin
            beat.mode      = MODE_ADD;
            beat.slope     = j;
            beat.intercept = -(j * j);
            beat.query_x   = $urandom;
            offer(beat, 1'b0, '0);
            if (j % 8 == 0) begin
                beat.mode      = MODE_QUERY;
                beat.slope     = $urandom;
                beat.intercept = $urandom;
                beat.query_x   = 2 * j;
                offer(beat, 1'b0, '0);
            end
            j++;
            guard++;
        end
        // adds onto the full stack are dropped and leave the flag set
        repeat (3) begin
            beat.mode      = MODE_ADD;
            beat.slope     = $urandom;
            beat.intercept = $urandom;
            offer(beat, 1'b0, '0);
        end
        for (int k = 0; k < 4; k++) begin
            beat.mode    = MODE_QUERY;
            beat.query_x = (k == 3) ? MAX32 : 2 * j + k * 1000;
            offer(beat, 1'b0, '0);
        end
    endtask

    task automatic check_answer(input t_out_item got);
        t_out_item want;
        if (max_answers_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected result: value %0d st %0b ovf %0b",
                         got.max_value, got.status, got.overflowed);
        end else begin
            want = max_answers_q.pop_front();
            if (got.max_value !== want.max_value || got.status !== want.status ||
                got.overflowed !== want.overflowed) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("mismatch: got %0d st %0b ovf %0b, want %0d st %0b ovf %0b",
                             got.max_value, got.status, got.overflowed,
                             want.max_value, want.status, want.overflowed);
            end
        end
    endtask

    // result side: random idling plus one long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_ready && out_valid) check_answer(out_data);
            if (pressure_req && !pressure_seen) begin
                pressure_seen <= 1'b1;
                stall_left    <= 400;
                out_ready     <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        t_in_item  beat;
        t_out_item want;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 9;
        recv_idle_pct <= 87;
        for (int i = 0; i < SCRIPT_LEN; i++) begin
            beat.mode       = SCRIPT[i].mode;
            beat.slope      = SCRIPT[i].slope;
            beat.intercept  = SCRIPT[i].intercept;
            beat.query_x    = SCRIPT[i].query_x;
            want.max_value  = SCRIPT[i].want_value;
            want.status     = SCRIPT[i].want_status;
            want.overflowed = 1'b0;
            offer(beat, SCRIPT[i].typed, want);
        end
        run_random(160);

        send_idle_pct = 87;
        recv_idle_pct <= 9;
        run_random(160);

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        pressure_req <= 1'b1;
        run_random(160);
        fill_to_overflow();
        in_valid <= 1'b0;

        while (max_answers_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #12_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
